[hw/rtl/stable_priority_queue_with_filters_unit_macros.svh]
// Assertion macros shared by the stable priority queue RTL
`ifndef STABLE_PRIORITY_QUEUE_WITH_FILTERS_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_WITH_FILTERS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPQF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SPQF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/spqf_pkg.sv]
// Types, codes and sizes of the stable priority queue
package spqf_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = $clog2(2 * DEPTH);

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_POP   = 3'd1,
        CMD_ALL   = 3'd2,
        CMD_GPA   = 3'd3,
        CMD_GRADE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_ENTRY = 2'd0,
        STAT_ADDED = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LIST
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  grade;
        logic [8:0]  gpa;
        logic [7:0]  attempts;
    } t_rec;

    typedef struct packed {
        t_cell_op   op;
        logic [2:0] mode;
        t_rec       key;
    } t_cell_ctrl;

    typedef struct packed {
        t_status status;
        t_rec    rec;
        logic    last;
    } t_result;

endpackage

[hw/rtl/spqf_if.sv]
// Valid/ready channel interfaces for command words and result words
interface spqf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] student_id;
    logic [7:0]  grade_letter;
    logic [8:0]  gpa_value;
    logic [7:0]  attempts_count;

    modport source (output valid, command, student_id, grade_letter, gpa_value,
                    attempts_count, input ready);
    modport sink (input valid, command, student_id, grade_letter, gpa_value,
                  attempts_count, output ready);
endinterface

interface spqf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] entry_id;
    logic [7:0]  entry_grade;
    logic [8:0]  entry_gpa;
    logic [7:0]  entry_attempts;
    logic        last;

    modport source (output valid, status, entry_id, entry_grade, entry_gpa,
                    entry_attempts, last, input ready);
    modport sink (input valid, status, entry_id, entry_grade, entry_gpa,
                  entry_attempts, last, output ready);
endinterface

[hw/rtl/stable_priority_queue_with_filters_unit.sv]
// Stable priority queue top: command control, ring of record cells, result register.
// Add and pop: an accepted word waits in ST_EXEC until the result register is free, then executes and loads it.
// List commands rotate the DEPTH-cell ring once, one cell per cycle, pausing while a matching
// entry waits on the result register; a list with no match leaves the ring untouched.
// Throughput: one command at a time; the rotation length sets the list command cost.
// Reset (synchronous, active low) clears occupancy, control and result valid; cells keep data.
module stable_priority_queue_with_filters_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    spqf_in_if.sink    i_in,
    spqf_out_if.source o_out
);
    import spqf_pkg::*;

    `include "stable_priority_queue_with_filters_unit_macros.svh"

    // control registers
    t_state            r_state;
    t_state            n_state;
    logic [2:0]        r_cmd;
    t_rec              r_key;
    logic [CNT_W-1:0]  r_occ;
    logic [CNT_W-1:0]  n_occ;
    logic [IDX_W-1:0]  r_k;
    logic [IDX_W-1:0]  n_k;

    // result register
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              w_out_load;
    logic              w_slot_free;

    // cell ring
    t_cell_ctrl        w_ctrl;
    t_rec              w_rec   [DEPTH];
    logic [DEPTH-1:0]  w_keep;
    logic [DEPTH-1:0]  w_match;
    logic [DEPTH-1:0]  w_valid;
    logic [DEPTH-1:0]  w_live;

    logic              w_accept;
    logic              w_any;
    logic              w_rest;
    logic              w_head_sel;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;

    // Cell i holds a record when i is below occupancy. During a list pass the
    // ring has turned r_k places, so cell i then holds original entry i + r_k.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam int RIGHT = (gi + 1) % DEPTH;
            localparam int LEFT  = (gi + DEPTH - 1) % DEPTH;
            logic w_prev_keep;

            assign w_valid[gi] = (CNT_W'(gi) < r_occ);
            assign w_live[gi]  = (SUM_W'(gi) + SUM_W'(r_k)) < SUM_W'(r_occ);

            if (gi == 0) begin : g_head
                // head boundary: a key that no cell keeps lands in the head
                assign w_prev_keep = 1'b1;
            end else begin : g_body
                assign w_prev_keep = w_keep[gi-1];
            end

            spqf_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_valid     (w_valid[gi]),
                .i_prev_keep (w_prev_keep),
                .i_left      (w_rec[LEFT]),
                .i_right     (w_rec[RIGHT]),
                .o_rec       (w_rec[gi]),
                .o_keep      (w_keep[gi]),
                .o_match     (w_match[gi])
            );
        end
    endgenerate

    // any selected entry still ahead in this pass, with and without the head
    assign w_any      = |(w_match & w_live);
    assign w_rest     = |(w_match & w_live & {{(DEPTH-1){1'b1}}, 1'b0});
    assign w_head_sel = w_match[0] && w_live[0];

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_k         = r_k;
        w_out_load  = 1'b0;
        n_out       = '0;
        n_out.last  = 1'b1;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.mode = r_cmd;
        w_ctrl.key  = r_key;
        i_in.ready  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                // ready is high here, so a valid word is taken at this edge
                if (i_in.valid) begin
                    case (i_in.command)
                        CMD_ADD, CMD_POP:           n_state = ST_EXEC;
                        CMD_ALL, CMD_GPA, CMD_GRADE: begin
                            n_state = ST_LIST;
                            n_k     = '0;
                        end
                        // unused codes: drop the word, no result
                        default:                    n_state = ST_IDLE;
                    endcase
                end
            end

            ST_EXEC: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                    if (r_cmd == CMD_ADD) begin
                        if (r_occ == CNT_W'(DEPTH)) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            n_out.status = STAT_ADDED;
                            w_ctrl.op    = CELL_INSERT;
                            n_occ        = r_occ + CNT_W'(1);
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_out.status = STAT_EMPTY;
                        end else begin
                            // pop: hand out the head, advance the chain left
                            n_out.status = STAT_ENTRY;
                            n_out.rec    = w_rec[0];
                            w_ctrl.op    = CELL_SHIFT;
                            n_occ        = r_occ - CNT_W'(1);
                        end
                    end
                end
            end

            ST_LIST: begin
                if (r_k == '0 && !w_any) begin
                    // nothing selected: report no match, ring untouched
                    if (w_slot_free) begin
                        w_out_load   = 1'b1;
                        n_out.status = STAT_EMPTY;
                        n_state      = ST_IDLE;
                    end
                end else if (!w_head_sel || w_slot_free) begin
                    if (w_head_sel) begin
                        w_out_load   = 1'b1;
                        n_out.status = STAT_ENTRY;
                        n_out.rec    = w_rec[0];
                        n_out.last   = !w_rest;
                    end
                    // turn the whole ring so the order is back after DEPTH steps
                    w_ctrl.op = CELL_SHIFT;
                    if (r_k == IDX_W'(DEPTH - 1)) begin
                        n_k     = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_k     <= n_k;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd          <= i_in.command;
            r_key.id       <= i_in.student_id;
            r_key.grade    <= i_in.grade_letter;
            r_key.gpa      <= i_in.gpa_value;
            r_key.attempts <= i_in.attempts_count;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.entry_id       = r_out.rec.id;
    assign o_out.entry_grade    = r_out.rec.grade;
    assign o_out.entry_gpa      = r_out.rec.gpa;
    assign o_out.entry_attempts = r_out.rec.attempts;
    assign o_out.last           = r_out.last;

    `SPQF_ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CNT_W'(DEPTH), "occupancy above depth")
    `SPQF_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_out_load, w_slot_free, "result overwritten before taken")
    `SPQF_ASSERT_IMPL(a_mid_in_list, i_clk, i_rst_n, w_out_load && !n_out.last, r_state == ST_LIST, "non-final result outside list")
    `SPQF_ASSERT_NEXT(a_no_grow, i_clk, i_rst_n, r_state != ST_EXEC || r_cmd != CMD_ADD, r_occ <= $past(r_occ), "occupancy grew without add")
    `SPQF_ASSERT_IMPL(a_list_restore, i_clk, i_rst_n, r_state == ST_LIST && n_state == ST_IDLE, r_k == '0 || r_k == IDX_W'(DEPTH - 1), "list left ring turned")

endmodule

[hw/rtl/spqf_cell.sv]
// One queue cell: holds a record, inserts, shifts and matches filters
module spqf_cell (
    input  logic                i_clk,
    input  spqf_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,
    input  logic                i_prev_keep,
    input  spqf_pkg::t_rec      i_left,
    input  spqf_pkg::t_rec      i_right,
    output spqf_pkg::t_rec      o_rec,
    output logic                o_keep,
    output logic                o_match
);
    import spqf_pkg::*;

    t_rec r_rec;
    t_rec n_rec;

    assign o_rec  = r_rec;
    // stay in place on insert: valid and not below the new key
    assign o_keep = i_valid && (r_rec.attempts >= i_ctrl.key.attempts);

    always_comb begin
        case (i_ctrl.mode)
            CMD_GPA:   o_match = (r_rec.gpa >= i_ctrl.key.gpa);
            CMD_GRADE: o_match = (r_rec.grade <= i_ctrl.key.grade);
            default:   o_match = 1'b1;
        endcase
    end

    always_comb begin
        n_rec = r_rec;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (!o_keep) begin
                    n_rec = i_prev_keep ? i_ctrl.key : i_left;
                end
            end
            CELL_SHIFT: n_rec = i_right;
            default:    n_rec = r_rec;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

[test/spqf_queue_checker.sv]
// Checker for the stable priority queue: watches both channels, predicts result words, compares
module spqf_queue_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    spqf_in_if   i_cmd,
    spqf_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import spqf_pkg::*;

    localparam int PRINT_CAP = 40;

    t_rec    queued_recs[$];
    t_result due_results[$];
    int      printed;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
        printed         = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        o_fail_count++;
        if (printed < PRINT_CAP) begin
            $display("checker: %s mismatch, expected 0x%0h, got 0x%0h at %0t",
                     what, want, got, $realtime);
        end
        printed++;
    endtask

    // Apply one accepted command word to the shadow queue and queue up its result words.
    task automatic apply_command(input logic [2:0] code, input t_rec word_rec);
        int      slot;
        int      picks[$];
        t_result res;
        res      = '0;
        res.last = 1'b1;
        case (code)
            CMD_ADD: begin
                if (queued_recs.size() >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // land behind every entry with attempts >= the new one
                    slot = 0;
                    while (slot < queued_recs.size() &&
                           queued_recs[slot].attempts >= word_rec.attempts) slot++;
                    queued_recs.insert(slot, word_rec);
                    res.status = STAT_ADDED;
                end
                due_results.push_back(res);
            end
            CMD_POP: begin
                if (queued_recs.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.status = STAT_ENTRY;
                    res.rec    = queued_recs.pop_front();
                end
                due_results.push_back(res);
            end
            CMD_ALL, CMD_GPA, CMD_GRADE: begin
                foreach (queued_recs[k]) begin
                    if (code == CMD_ALL ||
                        (code == CMD_GPA && queued_recs[k].gpa >= word_rec.gpa) ||
                        (code == CMD_GRADE && queued_recs[k].grade <= word_rec.grade))
                        picks.push_back(k);
                end
                if (picks.size() == 0) begin
                    res.status = STAT_EMPTY;
                    due_results.push_back(res);
                end else begin
                    foreach (picks[n]) begin
                        res.status = STAT_ENTRY;
                        res.rec    = queued_recs[picks[n]];
                        res.last   = (n == picks.size() - 1);
                        due_results.push_back(res);
                    end
                end
            end
            default: ;  // spare codes: drop, no result
        endcase
    endtask

    task automatic check_word();
        t_result want;
        o_words_checked++;
        if (due_results.size() == 0) begin
            report_mismatch("unexpected result word, status", '0, i_res.status);
        end else begin
            want = due_results.pop_front();
            if (i_res.status !== want.status)
                report_mismatch("status", want.status, i_res.status);
            if (i_res.entry_id !== want.rec.id)
                report_mismatch("entry_id", want.rec.id, i_res.entry_id);
            if (i_res.entry_grade !== want.rec.grade)
                report_mismatch("entry_grade", want.rec.grade, i_res.entry_grade);
            if (i_res.entry_gpa !== want.rec.gpa)
                report_mismatch("entry_gpa", want.rec.gpa, i_res.entry_gpa);
            if (i_res.entry_attempts !== want.rec.attempts)
                report_mismatch("entry_attempts", want.rec.attempts, i_res.entry_attempts);
            if (i_res.last !== want.last)
                report_mismatch("last", want.last, i_res.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            queued_recs.delete();
            due_results.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready)
                apply_command(i_cmd.command, t_rec'{id: i_cmd.student_id,
                                                    grade: i_cmd.grade_letter,
                                                    gpa: i_cmd.gpa_value,
                                                    attempts: i_cmd.attempts_count});
            if (i_res.valid && i_res.ready)
                check_word();
        end
        o_pending = due_results.size();
    end

endmodule

[test/tb_top.sv]
// Top of the stable priority queue testbench: clock, reset, command stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spqf_pkg::*;

    // Spare command codes that the block must ignore
    localparam logic [2:0] FIRST_SPARE_CMD = 3'd5;
    localparam logic [2:0] LAST_SPARE_CMD  = 3'd7;
    localparam logic [7:0] LETTER_A        = "A";
    localparam int         RANDOM_WORDS    = 360;
    // A list walks DEPTH cells; give the block that plus margin after the last result
    localparam int         DRAIN_CYCLES    = 4 * DEPTH;
    localparam int         QUIET_LIMIT     = 1000;

    logic i_clk;
    logic i_rst_n;

    spqf_in_if  cmd_if ();
    spqf_out_if res_if ();

    int fail_count;
    int pending;
    int words_checked;

    // Per-code tally of accepted command words, for the summary
    int sent_by_cmd [8];
    int live_words;
    // While set, neither side inserts idle cycles
    bit steady_flow;

    stable_priority_queue_with_filters_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    spqf_queue_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_if),
        .i_res           (res_if),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Offer one command word: idle a random number of cycles, then hold it until taken.
    // Entered and left at a falling edge.
    task automatic send_word(input logic [2:0] code, input logic [31:0] id,
                             input logic [7:0] grade, input logic [8:0] gpa,
                             input logic [7:0] tries);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.command        <= code;
        cmd_if.student_id     <= id;
        cmd_if.grade_letter   <= grade;
        cmd_if.gpa_value      <= gpa;
        cmd_if.attempts_count <= tries;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
        sent_by_cmd[code]++;
        if (code <= CMD_GRADE) live_words++;
    endtask

    // Mostly real letters, sometimes any byte
    function automatic logic [7:0] draw_grade();
        if ($urandom_range(0, 3) != 0) return 8'(LETTER_A + $urandom_range(0, 5));
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly legal gpa, sometimes the out-of-range top of the 9-bit field
    function automatic logic [8:0] draw_gpa();
        if ($urandom_range(0, 3) != 0) return 9'($urandom_range(0, 400));
        return 9'($urandom_range(0, 511));
    endfunction

    // Small attempt counts half the time, so ties are common
    function automatic logic [7:0] draw_tries();
        if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_add();
        send_word(CMD_ADD, $urandom, draw_grade(), draw_gpa(), draw_tries());
    endtask

    task automatic send_mixed_word();
        int         pick;
        logic [2:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 40)      code = CMD_ADD;
        else if (pick < 60) code = CMD_POP;
        else if (pick < 72) code = CMD_ALL;
        else if (pick < 84) code = CMD_GPA;
        else if (pick < 96) code = CMD_GRADE;
        else                code = 3'($urandom_range(FIRST_SPARE_CMD, LAST_SPARE_CMD));
        send_word(code, $urandom, draw_grade(), draw_gpa(), draw_tries());
    endtask

    // Drop valid, then hold new commands until every predicted result word has come back
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Result side: stall a random number of cycles before taking each word
    initial begin : result_sink
        int stall;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            @(negedge i_clk);
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d result words outstanding",
                 QUIET_LIMIT, pending);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int kind;
        cmd_if.valid          = 1'b0;
        cmd_if.command        = CMD_ADD;
        cmd_if.student_id     = '0;
        cmd_if.grade_letter   = '0;
        cmd_if.gpa_value      = '0;
        cmd_if.attempts_count = '0;
        i_rst_n               = 1'b0;
        steady_flow           = 1'b0;
        live_words            = 0;
        foreach (sent_by_cmd[c]) sent_by_cmd[c] = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: everything on an empty queue reports empty
        send_word(CMD_POP,   '0, '0, '0, '0);
        send_word(CMD_ALL,   '0, '0, '0, '0);
        send_word(CMD_GPA,   '0, '0, 9'd0, '0);
        send_word(CMD_GRADE, '0, 8'hFF, '0, '0);

        // Field extremes, then ties on attempts: two records at 5 and two at the top value 255
        send_word(CMD_ADD, 32'h0000_0000, 8'h00, 9'd0,   8'd0);
        send_word(CMD_ADD, 32'hFFFF_FFFF, 8'hFF, 9'd511, 8'd255);
        send_word(CMD_ADD, 32'd1, "B", 9'd350, 8'd5);
        send_word(CMD_ADD, 32'd2, "A", 9'd400, 8'd5);
        send_word(CMD_ADD, 32'd3, "C", 9'd200, 8'd255);

        // Spare codes: no result, no change
        for (int c = FIRST_SPARE_CMD; c <= LAST_SPARE_CMD; c++)
            send_word(3'(c), $urandom, 8'($urandom), 9'($urandom), 8'($urandom));

        // Every list flavor at its thresholds
        send_word(CMD_ALL,   '0, '0, '0, '0);
        send_word(CMD_GPA,   '0, '0, 9'd400, '0);
        send_word(CMD_GPA,   '0, '0, 9'd511, '0);
        send_word(CMD_GPA,   '0, '0, 9'd0, '0);
        send_word(CMD_GRADE, '0, "B", '0, '0);
        send_word(CMD_GRADE, '0, 8'h00, '0, '0);
        send_word(CMD_GRADE, '0, 8'hFF, '0, '0);

        // Pop both top-priority records, then a filter that matches nothing left
        send_word(CMD_POP, '0, '0, '0, '0);
        send_word(CMD_POP, '0, '0, '0, '0);
        send_word(CMD_GPA, '0, '0, 9'd401, '0);

        wait_drained();

        // Random rounds: mostly well-formed traffic, with fill/drain bursts and some noise
        while (live_words < RANDOM_WORDS) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    // overfill: capacity is DEPTH, so the tail adds hit the full case
                    repeat (DEPTH + 2) send_add();
                    send_word(CMD_ALL, '0, '0, '0, '0);
                end
                1: begin
                    // drain past empty
                    repeat (DEPTH + 2) send_word(CMD_POP, '0, '0, '0, '0);
                end
                9: begin
                    repeat (6)
                        send_word(3'($urandom_range(0, 7)), $urandom,
                                  8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)),
                                  8'($urandom_range(0, 255)));
                end
                default: begin
                    repeat (12) send_mixed_word();
                end
            endcase
            if ($urandom_range(0, 3) == 0) wait_drained();
        end

        steady_flow = 1'b0;
        cmd_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("summary: %0d commands (%0d add, %0d pop, %0d list, %0d spare codes)",
                 live_words + sent_by_cmd[5] + sent_by_cmd[6] + sent_by_cmd[7],
                 sent_by_cmd[CMD_ADD], sent_by_cmd[CMD_POP],
                 sent_by_cmd[CMD_ALL] + sent_by_cmd[CMD_GPA] + sent_by_cmd[CMD_GRADE],
                 sent_by_cmd[5] + sent_by_cmd[6] + sent_by_cmd[7]);
        $display("summary: %0d result words checked, %0d mismatches", words_checked,
                 fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
